// File: sv/ptmoc_pkg.sv
// ----------------------------------------------------------------------------
// ptmoc_pkg
// types and constants shared by the periodic trial move overlap check
// ----------------------------------------------------------------------------
`default_nettype none

package ptmoc_pkg;

    localparam int COORD_W    = 24;
    localparam int HALF_W     = 23;
    localparam int THR_W      = 48;
    localparam int COUNT_W    = 9;
    localparam int INDEX_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // remainder unit: dividend below 2^25, divisor is the box span
    localparam int DVD_W     = 25;
    localparam int DSR_W     = 24;
    localparam int REM_STEPS = DVD_W;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TRY  = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OVERLAP = 2'd1;
    localparam logic [1:0] STATUS_RANGE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SQ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 3'd4;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic                 mode;
        logic [INDEX_W-1:0]   index;
        coord_t               val_x;
        coord_t               val_y;
        coord_t               val_z;
    } ptmoc_cmd_t;

    typedef struct packed {
        logic [1:0] status;
        coord_t     pos_x;
        coord_t     pos_y;
        coord_t     pos_z;
    } ptmoc_result_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } ptmoc_rem_req_t;

    typedef struct packed {
        logic             done;
        logic [DSR_W-1:0] rem;
    } ptmoc_rem_rsp_t;

endpackage

`default_nettype wire

// File: sv/ptmoc_rem.sv
// ----------------------------------------------------------------------------
// ptmoc_rem
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ptmoc_rem
    import ptmoc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  ptmoc_rem_req_t req,
    output ptmoc_rem_rsp_t rsp
);

    localparam int CNT_W = $clog2(REM_STEPS + 1);

    logic             run_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W-1:0] rem_reg;

    logic [DSR_W:0]   shifted;
    logic [DSR_W+1:0] trial;

    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(REM_STEPS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            // keep the shifted remainder when the trial subtract goes negative
            rem_reg <= trial[DSR_W+1] ? shifted[DSR_W-1:0] : trial[DSR_W-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// File: sv/periodic_trial_move_overlap_check_top.sv
// ----------------------------------------------------------------------------
// periodic_trial_move_overlap_check_top
// minimum-image overlap check of one trial particle move in a periodic box
// ----------------------------------------------------------------------------
//
//  channel  | signals                                  | transfer
//  ---------+------------------------------------------+---------------------------
//  command  | start, busy, cmd (ptmoc_cmd_t)           | start high and busy low
//  result   | done, result (ptmoc_result_t)            | done high, one cycle each
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data| cfg_valid and cfg_ready
//
//  load and out-of-range try: result strobed in the cycle after the transfer
//  try: the scan reads one stored position per cycle from the two position
//    memories, while no wrap is waiting on the remainder unit
//  each axis whose value lies one span or more outside the box waits on
//    the shared bit-serial remainder unit
//  after reset the moved store is cleared, one entry a cycle, with busy high;
//    config writes are taken throughout
//  the receiver cannot stall: every result shows on done for one cycle
//
`default_nettype none

module periodic_trial_move_overlap_check_top
    import ptmoc_pkg::*;
#(
    parameter int MAX_PARTICLES = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ptmoc_cmd_t            cmd,
    output logic                  done,
    output ptmoc_result_t         result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // address width of the position stores, count width and compare width
    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam int IW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int WW = 3 * COORD_W;
    localparam int XW = COORD_W + 2;
    localparam int SQ_W = 2 * HALF_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REF,
        ST_CAND,
        ST_SCAN
    } state_t;

    // outcome of the one-step wrap of one axis
    typedef struct packed {
        logic             slow;
        logic             above;
        logic [DVD_W-1:0] dvd;
        coord_t           val;
    } wrap_t;

    // wrap into [-L, L] when one span is enough, else flag for the remainder unit
    function automatic wrap_t wrap_fast(input logic signed [XW-1:0] x,
                                        input logic [HALF_W-1:0] half);
        logic signed [XW-1:0] h;
        logic signed [XW-1:0] s;
        logic signed [XW-1:0] up;
        logic signed [XW-1:0] dn;
        wrap_t                w;
        h       = $signed({3'b000, half});
        s       = $signed({2'b00, half, 1'b0});
        up      = x - h;
        dn      = -h - x;
        w.slow  = 1'b0;
        w.above = 1'b0;
        w.dvd   = up[DVD_W-1:0];
        w.val   = x[COORD_W-1:0];
        if (x > h)
        begin
            w.above = 1'b1;
            if (up < s)
                w.val = COORD_W'(x - s);
            else
                w.slow = 1'b1;
        end
        else if (x < -h)
        begin
            w.dvd = dn[DVD_W-1:0];
            if (dn < s)
                w.val = COORD_W'(x + s);
            else
                w.slow = 1'b1;
        end
        return w;
    endfunction

    // config registers
    logic [HALF_W-1:0]  half_len_reg [3];
    logic [THR_W-1:0]   min_dist_sq_reg;
    logic [COUNT_W-1:0] count_reg;

    // control
    state_t             state_reg;
    logic               done_reg;
    ptmoc_result_t      result_reg;
    logic [AW-1:0]      clr_reg;
    logic [CW-1:0]      i_reg;
    logic               overlap_reg;
    logic               p1_vld_reg;
    logic               p1_moved_reg;
    logic               p2_vld_reg;
    logic               abs_vld_reg;
    logic               sq_vld_reg;
    logic               div_active_reg;
    logic               div_start_reg;
    logic [1:0]         div_axis_reg;
    logic               div_above_reg;
    logic [DVD_W-1:0]   div_dvd_reg;
    logic [DSR_W-1:0]   div_dsr_reg;

    // datapath
    logic [INDEX_W-1:0]    idx_reg;
    logic                  in_store_reg;
    logic [CW-1:0]         n_reg;
    coord_t                v_reg    [3];
    logic signed [XW-1:0]  x_reg    [3];
    coord_t                cand_reg [3];
    logic [HALF_W-1:0]     abs_reg  [3];
    logic [SQ_W-1:0]       sq_reg   [3];

    // position stores
    logic [WW-1:0] ref_mem [MAX_PARTICLES];
    logic [WW-1:0] mv_mem  [MAX_PARTICLES];
    logic [WW-1:0] ref_rd_reg;
    logic [WW-1:0] mv_rd_reg;

    // combinational
    logic [HALF_W-1:0]    half_eff [3];
    wrap_t                wr       [3];
    coord_t               ref_c    [3];
    coord_t               other_c  [3];
    logic [HALF_W-1:0]    mag      [3];
    logic                 any_slow;
    logic                 p2_active;
    logic                 stall;
    logic                 div_launch;
    logic [1:0]           slow_axis;
    logic                 issue;
    logic                 hit_self;
    logic                 below_idx;
    logic                 accept;
    logic                 cmd_in_store;
    logic                 disp_bad;
    logic                 scan_done;
    logic [THR_W-1:0]     sum_sq;
    logic signed [XW-1:0] div_res;
    logic                 ref_re;
    logic                 ref_we;
    logic [AW-1:0]        ref_raddr;
    logic                 mv_we;
    logic [AW-1:0]        mv_waddr;
    logic [WW-1:0]        mv_wdata;
    logic [WW-1:0]        other_word;
    logic [WW-1:0]        cmd_word;
    logic [WW-1:0]        cand_word;
    coord_t               cmd_v    [3];
    logic signed [COORD_W:0] disp_mag [3];

    ptmoc_rem_req_t rem_req;
    ptmoc_rem_rsp_t rem_rsp;

    ptmoc_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    assign rem_req.start    = div_start_reg;
    assign rem_req.dividend = div_dvd_reg;
    assign rem_req.divisor  = div_dsr_reg;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign cmd_v[0]  = cmd.val_x;
    assign cmd_v[1]  = cmd.val_y;
    assign cmd_v[2]  = cmd.val_z;
    assign cmd_word  = {cmd.val_x, cmd.val_y, cmd.val_z};
    assign cand_word = {cand_reg[0], cand_reg[1], cand_reg[2]};

    assign cmd_in_store = (IW'(cmd.index) < IW'(MAX_PARTICLES));

    // a zero half length acts as one
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            half_eff[k] = (half_len_reg[k] == '0) ? HALF_W'(1) : half_len_reg[k];
    end

    // displacement beyond two half lengths on any axis
    always_comb
    begin
        disp_bad = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            disp_mag[k] = cmd_v[k][COORD_W-1] ? -(COORD_W+1)'(cmd_v[k])
                                              : (COORD_W+1)'(cmd_v[k]);
            if (disp_mag[k] > $signed({1'b0, half_eff[k], 1'b0}))
                disp_bad = 1'b1;
        end
    end

    // wrap stage, shared by the candidate and by each scanned distance
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            wr[k]  = wrap_fast(x_reg[k], half_eff[k]);
            mag[k] = wr[k].val[COORD_W-1] ? HALF_W'(-wr[k].val)
                                          : wr[k].val[HALF_W-1:0];
        end
    end

    assign any_slow  = wr[0].slow || wr[1].slow || wr[2].slow;
    assign p2_active = (state_reg == ST_CAND) || ((state_reg == ST_SCAN) && p2_vld_reg);
    assign stall     = p2_active && (any_slow || div_active_reg);
    assign div_launch = p2_active && any_slow && !div_active_reg;

    always_comb
    begin
        priority if (wr[0].slow)
            slow_axis = 2'd0;
        else if (wr[1].slow)
            slow_axis = 2'd1;
        else
            slow_axis = 2'd2;
    end

    // wrapped value from the remainder of the excess over one half length
    always_comb
    begin
        logic signed [XW-1:0] h;
        logic signed [XW-1:0] r;
        h = $signed({3'b000, half_eff[div_axis_reg]});
        r = $signed({2'b00, rem_rsp.rem});
        if (div_above_reg)
            div_res = (rem_rsp.rem == '0) ? h : r - h;
        else
            div_res = (rem_rsp.rem == '0) ? -h : h - r;
    end

    // scan issue and the order against the trial index
    assign hit_self  = (IW'(i_reg) == IW'(idx_reg));
    assign below_idx = (IW'(i_reg) < IW'(idx_reg));
    assign issue     = (state_reg == ST_SCAN) && !stall && !overlap_reg && (i_reg < n_reg);

    assign other_word = p1_moved_reg ? mv_rd_reg : ref_rd_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ref_c[k]   = in_store_reg ? $signed(ref_rd_reg[(2-k)*COORD_W +: COORD_W]) : '0;
            other_c[k] = $signed(other_word[(2-k)*COORD_W +: COORD_W]);
        end
    end

    assign sum_sq = THR_W'(sq_reg[0]) + THR_W'(sq_reg[1]) + THR_W'(sq_reg[2]);

    assign scan_done = ((i_reg == n_reg) || overlap_reg) && !p1_vld_reg && !p2_vld_reg
                       && !abs_vld_reg && !sq_vld_reg;

    // memory ports
    assign ref_re    = (accept && (cmd.mode == MODE_TRY)) || issue;
    assign ref_raddr = (state_reg == ST_IDLE) ? AW'(cmd.index) : i_reg[AW-1:0];
    assign ref_we    = accept && (cmd.mode == MODE_LOAD) && cmd_in_store;

    assign mv_we    = (state_reg == ST_CLEAR)
                      || ((state_reg == ST_SCAN) && scan_done && !overlap_reg && in_store_reg);
    assign mv_waddr = (state_reg == ST_CLEAR) ? clr_reg : AW'(idx_reg);
    assign mv_wdata = (state_reg == ST_CLEAR) ? '0 : cand_word;

    always_ff @(posedge clk)
    begin
        if (ref_we)
            ref_mem[AW'(cmd.index)] <= cmd_word;
        if (ref_re)
            ref_rd_reg <= ref_mem[ref_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mv_we)
            mv_mem[mv_waddr] <= mv_wdata;
        if (issue)
            mv_rd_reg <= mv_mem[i_reg[AW-1:0]];
    end

    // config writes, indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_len_reg[0] <= HALF_W'(655360);
            half_len_reg[1] <= HALF_W'(655360);
            half_len_reg[2] <= HALF_W'(655360);
            min_dist_sq_reg <= THR_W'(1288490189);
            count_reg       <= COUNT_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HALF_X: half_len_reg[0] <= cfg_data[HALF_W-1:0];
                CFG_HALF_Y: half_len_reg[1] <= cfg_data[HALF_W-1:0];
                CFG_HALF_Z: half_len_reg[2] <= cfg_data[HALF_W-1:0];
                CFG_MIN_SQ: min_dist_sq_reg <= cfg_data[THR_W-1:0];
                CFG_COUNT:  count_reg       <= cfg_data[COUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // sequencer, scan pipeline valids and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            done_reg       <= 1'b0;
            result_reg     <= '0;
            clr_reg        <= '0;
            i_reg          <= '0;
            overlap_reg    <= 1'b0;
            p1_vld_reg     <= 1'b0;
            p1_moved_reg   <= 1'b0;
            p2_vld_reg     <= 1'b0;
            abs_vld_reg    <= 1'b0;
            sq_vld_reg     <= 1'b0;
            div_active_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            div_axis_reg   <= '0;
            div_above_reg  <= 1'b0;
            div_dvd_reg    <= '0;
            div_dsr_reg    <= '0;
        end
        else
        begin
            done_reg      <= 1'b0;
            div_start_reg <= div_launch;
            if (div_launch)
            begin
                div_active_reg <= 1'b1;
                div_axis_reg   <= slow_axis;
                div_above_reg  <= wr[slow_axis].above;
                div_dvd_reg    <= wr[slow_axis].dvd;
                div_dsr_reg    <= {half_eff[slow_axis], 1'b0};
            end
            else if (rem_rsp.done)
            begin
                div_active_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(MAX_PARTICLES - 1))
                        state_reg <= ST_IDLE;
                end

                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (cmd.mode == MODE_LOAD)
                        begin
                            done_reg          <= 1'b1;
                            result_reg.status <= STATUS_OK;
                            result_reg.pos_x  <= cmd.val_x;
                            result_reg.pos_y  <= cmd.val_y;
                            result_reg.pos_z  <= cmd.val_z;
                        end
                        else if (disp_bad)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '{status: STATUS_RANGE, default: '0};
                        end
                        else
                        begin
                            state_reg <= ST_REF;
                        end
                    end
                end

                ST_REF:
                begin
                    state_reg <= ST_CAND;
                end

                ST_CAND:
                begin
                    if (!stall)
                    begin
                        state_reg   <= ST_SCAN;
                        i_reg       <= '0;
                        overlap_reg <= 1'b0;
                        p1_vld_reg  <= 1'b0;
                        p2_vld_reg  <= 1'b0;
                        abs_vld_reg <= 1'b0;
                        sq_vld_reg  <= 1'b0;
                    end
                end

                ST_SCAN:
                begin
                    if (issue)
                        i_reg <= i_reg + CW'(1);
                    if (!stall)
                    begin
                        p1_vld_reg   <= issue && !hit_self;
                        p1_moved_reg <= below_idx;
                        p2_vld_reg   <= p1_vld_reg;
                    end
                    abs_vld_reg <= p2_vld_reg && !stall;
                    sq_vld_reg  <= abs_vld_reg;
                    if (sq_vld_reg && (sum_sq < min_dist_sq_reg))
                        overlap_reg <= 1'b1;
                    if (scan_done)
                    begin
                        state_reg         <= ST_IDLE;
                        done_reg          <= 1'b1;
                        result_reg.status <= overlap_reg ? STATUS_OVERLAP : STATUS_OK;
                        result_reg.pos_x  <= cand_reg[0];
                        result_reg.pos_y  <= cand_reg[1];
                        result_reg.pos_z  <= cand_reg[2];
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg      <= cmd.index;
            in_store_reg <= cmd_in_store;
            n_reg        <= (IW'(count_reg) > IW'(MAX_PARTICLES)) ? CW'(MAX_PARTICLES)
                                                                 : CW'(count_reg);
            for (int k = 0; k < 3; k++)
                v_reg[k] <= cmd_v[k];
        end

        if (rem_rsp.done)
        begin
            x_reg[div_axis_reg] <= div_res;
        end
        else if (state_reg == ST_REF)
        begin
            for (int k = 0; k < 3; k++)
                x_reg[k] <= XW'(ref_c[k]) + XW'(v_reg[k]);
        end
        else if ((state_reg == ST_SCAN) && !stall)
        begin
            // candidate minus the other particle, wrapped in the next stage
            for (int k = 0; k < 3; k++)
                x_reg[k] <= XW'(cand_reg[k]) - XW'(other_c[k]);
        end

        if ((state_reg == ST_CAND) && !stall)
        begin
            for (int k = 0; k < 3; k++)
                cand_reg[k] <= wr[k].val;
        end

        for (int k = 0; k < 3; k++)
        begin
            abs_reg[k] <= mag[k];
            sq_reg[k]  <= SQ_W'(abs_reg[k]) * SQ_W'(abs_reg[k]);
        end
    end

    // an accepted item either answers at once or keeps the block busy
    a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done || busy))
        else $error("accepted item neither answered nor in work");

    // scan pipeline tokens live only during a scan
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_vld_reg || p2_vld_reg || abs_vld_reg || sq_vld_reg) |-> (state_reg == ST_SCAN))
        else $error("scan pipeline token outside scan");

    // the remainder unit runs only while a wrap is pending
    a_div_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        div_active_reg |-> ((state_reg == ST_CAND) || (state_reg == ST_SCAN)))
        else $error("remainder unit active outside a try");

    // the scan never runs past the particle count
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (i_reg <= n_reg))
        else $error("scan index beyond particle count");

    // no store write while a distance stage is stalled on the remainder unit
    a_no_write_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (stall && (state_reg == ST_SCAN)) |-> !mv_we)
        else $error("moved store written during a stalled scan");

endmodule

`default_nettype wire
